>>> hw/rtl/box_blur_3x3_edge_aware_macros.svh
// Assertion macros for the box blur block.
// Used by the top level only; the properties sample on clk and are disabled during rst.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define BB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next cycle.
`define BB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BB_ASSERT(label, prop, msg)
`define BB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hw/rtl/bblur_pkg.sv
// Shared constants and types for the 3x3 box blur.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bblur_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Configuration port.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam int WIDTH_RESET  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int HEIGHT_RESET = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  // Position and dimension widths.
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

  // Averaging arithmetic: nine 8-bit samples at most.
  localparam int CH_W      = 8;
  localparam int SUM_W     = 12;
  localparam int CNT_W     = 4;
  localparam int NUM_W     = SUM_W + 1;
  localparam int RCP_SHIFT = 17;
  localparam int RCP_W     = 17;
  localparam int PROD_W    = NUM_W + RCP_W;

  // Rounded-up reciprocals of twice the neighbour count, scaled by 2^RCP_SHIFT.
  localparam logic [RCP_W-1:0] RCP_CNT1 = RCP_W'(((1 << RCP_SHIFT) + 2 - 1) / 2);
  localparam logic [RCP_W-1:0] RCP_CNT2 = RCP_W'(((1 << RCP_SHIFT) + 4 - 1) / 4);
  localparam logic [RCP_W-1:0] RCP_CNT3 = RCP_W'(((1 << RCP_SHIFT) + 6 - 1) / 6);
  localparam logic [RCP_W-1:0] RCP_CNT4 = RCP_W'(((1 << RCP_SHIFT) + 8 - 1) / 8);
  localparam logic [RCP_W-1:0] RCP_CNT6 = RCP_W'(((1 << RCP_SHIFT) + 12 - 1) / 12);
  localparam logic [RCP_W-1:0] RCP_CNT9 = RCP_W'(((1 << RCP_SHIFT) + 18 - 1) / 18);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic sum;
    logic load_out;
  } bblur_cmd_t;

  typedef struct packed {
    logic drain_phase;
    logic emit;
  } bblur_status_t;

endpackage

>>> hw/rtl/bblur_avg.sv
// Rounded average of one channel: (2*sum + count) / (2*count).
// Uses bblur_pkg; the quotient comes from a reciprocal multiply that is exact for all sums.
`timescale 1ns / 1ps

module bblur_avg (
  input  logic [bblur_pkg::SUM_W-1:0] sum,
  input  logic [bblur_pkg::CNT_W-1:0] count,
  output logic [bblur_pkg::CH_W-1:0]  avg
);
  import bblur_pkg::*;

  logic [RCP_W-1:0]  rcp;
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;

  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    case (n)
      CNT_W'(1): return RCP_CNT1;
      CNT_W'(2): return RCP_CNT2;
      CNT_W'(3): return RCP_CNT3;
      CNT_W'(4): return RCP_CNT4;
      CNT_W'(6): return RCP_CNT6;
      CNT_W'(9): return RCP_CNT9;
      default:   return '0;
    endcase
  endfunction

  always_comb begin
    rcp  = recip(count);
    num  = {sum, 1'b0} + NUM_W'(count);
    prod = PROD_W'(num) * PROD_W'(rcp);
    avg  = prod[RCP_SHIFT +: CH_W];
  end

endmodule

>>> hw/rtl/bblur_dp.sv
// Datapath of the box blur: frame registers, position counters, two line stores,
// the 3x3 window, masked channel sums and the output register. Uses bblur_pkg, bblur_avg.
`timescale 1ns / 1ps

module bblur_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bblur_pkg::CFG_W-1:0]      cfg_data,
  input  logic [bblur_pkg::CH_W-1:0]       in_red,
  input  logic [bblur_pkg::CH_W-1:0]       in_green,
  input  logic [bblur_pkg::CH_W-1:0]       in_blue,
  input  bblur_pkg::bblur_cmd_t            cmd,
  output bblur_pkg::bblur_status_t         status,
  output logic [bblur_pkg::CH_W-1:0]       out_red,
  output logic [bblur_pkg::CH_W-1:0]       out_green,
  output logic [bblur_pkg::CH_W-1:0]       out_blue,
  output logic                             frame_last
);
  import bblur_pkg::*;

  logic [WDIM_W-1:0] frame_width;
  logic [HDIM_W-1:0] frame_height;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;

  pix_t upper_mem  [0:MAX_WIDTH-1];
  pix_t middle_mem [0:MAX_WIDTH-1];
  pix_t upper_rd;
  pix_t middle_rd;
  pix_t pix_hold;
  pix_t win [0:2][0:2];

  logic       last_hold;
  logic [2:0] col_mask;
  logic [2:0] row_mask;

  logic [SUM_W-1:0] sum_red;
  logic [SUM_W-1:0] sum_green;
  logic [SUM_W-1:0] sum_blue;
  logic [CNT_W-1:0] count;

  logic [SUM_W-1:0]  acc_red;
  logic [SUM_W-1:0]  acc_green;
  logic [SUM_W-1:0]  acc_blue;
  logic [1:0]        n_cols;
  logic [1:0]        n_rows;
  logic [CNT_W-1:0]  count_next;
  logic [CH_W-1:0]   avg_red;
  logic [CH_W-1:0]   avg_green;
  logic [CH_W-1:0]   avg_blue;

  logic [ROW_W-1:0]  height_ext;
  logic [ROW_W-1:0]  height_p1;
  logic [WDIM_W-1:0] col_inc;
  logic              emit;
  logic              is_last;
  logic              wrap;
  logic [2:0]        col_mask_next;
  logic [2:0]        row_mask_next;
  logic [WDIM_W-1:0] width_val;
  logic [HDIM_W-1:0] height_val;

  // Position decode. A result is due once the stream is one row and one pixel in,
  // and the final one falls on the first column two rows below the frame.
  always_comb begin
    height_ext = ROW_W'(frame_height);
    height_p1  = height_ext + ROW_W'(1);
    col_inc    = WDIM_W'(in_col) + WDIM_W'(1);
    wrap       = (col_inc >= frame_width);
    emit       = ((in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0))) &&
                 ((in_row < height_p1) || ((in_row == height_p1) && (in_col == '0)));
    is_last    = (in_row == height_p1) && (in_col == '0);
    // Masks refer to the window after the shift; bit 0 is the oldest column or top row.
    if (in_col == '0) begin
      col_mask_next = (frame_width > WDIM_W'(1)) ? 3'b011 : 3'b010;
      row_mask_next = {in_row <= height_ext, 1'b1, in_row >= ROW_W'(3)};
    end else begin
      col_mask_next = (in_col > COL_W'(1)) ? 3'b111 : 3'b110;
      row_mask_next = {in_row < height_ext, 1'b1, in_row >= ROW_W'(2)};
    end
    status.drain_phase = (in_row >= height_ext);
    status.emit        = emit;
  end

  // Out-of-range register values: zero counts as one, large values saturate.
  always_comb begin
    if (cfg_data == '0) begin
      width_val  = WDIM_W'(1);
      height_val = HDIM_W'(1);
    end else begin
      width_val  = (32'(cfg_data) > MAX_WIDTH) ? WDIM_W'(MAX_WIDTH) : WDIM_W'(cfg_data);
      height_val = (32'(cfg_data) > MAX_HEIGHT) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(cfg_data);
    end
  end

  always_comb begin
    acc_red   = '0;
    acc_green = '0;
    acc_blue  = '0;
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        if (row_mask[rr] && col_mask[cc]) begin
          acc_red   = acc_red + SUM_W'(win[rr][cc].red);
          acc_green = acc_green + SUM_W'(win[rr][cc].green);
          acc_blue  = acc_blue + SUM_W'(win[rr][cc].blue);
        end
      end
    end
    n_cols     = 2'($countones(col_mask));
    n_rows     = 2'($countones(row_mask));
    count_next = CNT_W'(n_cols) * CNT_W'(n_rows);
  end

  // Line stores: read every cycle at the current column, written on a step.
  always_ff @(posedge clk) begin
    upper_rd  <= upper_mem[in_col];
    middle_rd <= middle_mem[in_col];
    if (cmd.step) begin
      upper_mem[in_col]  <= middle_rd;
      middle_mem[in_col] <= pix_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WDIM_W'(WIDTH_RESET);
      frame_height <= HDIM_W'(HEIGHT_RESET);
      in_row       <= '0;
      in_col       <= '0;
      win          <= '{default: '0};
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= width_val;
        REG_FRAME_HEIGHT: frame_height <= height_val;
        default: ;
      endcase
      in_row <= '0;
      in_col <= '0;
      win    <= '{default: '0};
    end else if (cmd.step) begin
      for (int rr = 0; rr < 3; rr++) begin
        win[rr][0] <= win[rr][1];
        win[rr][1] <= win[rr][2];
      end
      win[0][2] <= upper_rd;
      win[1][2] <= middle_rd;
      win[2][2] <= pix_hold;
      if (emit && is_last) begin
        in_row <= '0;
        in_col <= '0;
      end else if (wrap) begin
        in_row <= in_row + ROW_W'(1);
        in_col <= '0;
      end else begin
        in_col <= in_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      // Pixels that arrive after the frame end act as drain steps with zero data.
      pix_hold <= status.drain_phase ? pix_t'('0) : pix_t'({in_red, in_green, in_blue});
    end
    if (cmd.step) begin
      last_hold <= is_last;
      col_mask  <= col_mask_next;
      row_mask  <= row_mask_next;
    end
    if (cmd.sum) begin
      sum_red   <= acc_red;
      sum_green <= acc_green;
      sum_blue  <= acc_blue;
      count     <= count_next;
    end
    if (cmd.load_out) begin
      out_red    <= avg_red;
      out_green  <= avg_green;
      out_blue   <= avg_blue;
      frame_last <= last_hold;
    end
  end

  bblur_avg u_avg_red (
    .sum   (sum_red),
    .count (count),
    .avg   (avg_red)
  );

  bblur_avg u_avg_green (
    .sum   (sum_green),
    .count (count),
    .avg   (avg_green)
  );

  bblur_avg u_avg_blue (
    .sum   (sum_blue),
    .count (count),
    .avg   (avg_blue)
  );

endmodule

>>> hw/rtl/bblur_ctrl.sv
// Controller of the box blur: sequences one stream position per step and owns
// both handshakes. Uses bblur_pkg for the command and status structs.
`timescale 1ns / 1ps

module bblur_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     req_type,
  input  logic                     out_stall,
  input  bblur_pkg::bblur_status_t status,
  output logic                     in_stall,
  output logic                     out_valid,
  output bblur_pkg::bblur_cmd_t    cmd
);
  import bblur_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_STEP,
    S_SUM,
    S_DIV
  } state_t;

  state_t state;
  logic   is_drain;
  logic   accept;

  always_comb begin
    accept       = (state == S_IDLE) && in_valid;
    in_stall     = (state != S_IDLE);
    cmd.capture  = accept;
    cmd.step     = (state == S_STEP);
    cmd.sum      = (state == S_SUM);
    cmd.load_out = (state == S_DIV) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      is_drain  <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_drain <= status.drain_phase;
            // A drain request inside the frame is dropped without any work.
            if (status.drain_phase || !req_type) begin
              state <= S_STEP;
            end
          end
        end
        S_READ: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (status.emit) begin
            state <= S_SUM;
          end else if (is_drain) begin
            // A drain position with no result is skipped; the next one is taken
            // within the same transfer once the line store read has settled.
            is_drain <= 1'b0;
            state    <= S_READ;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/box_blur_3x3_edge_aware.sv
// 3x3 box blur over RGB pixels in raster order, averaged over in-frame neighbours.
// A result reaches the output register through the controller's step, sum and divide
// states after its transfer; a skipped drain position adds a read and a second step on
// the single-port line stores. Transfers are taken only in the idle state, so none while
// the output stalls a result in divide; a dropped drain request leaves the controller idle.
// Reset (synchronous): frame 640x480, position and window cleared; line stores keep contents.
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_aware_macros.svh"

module box_blur_3x3_edge_aware (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [bblur_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bblur_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            req_type,
  input  logic [bblur_pkg::CH_W-1:0]      in_red,
  input  logic [bblur_pkg::CH_W-1:0]      in_green,
  input  logic [bblur_pkg::CH_W-1:0]      in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bblur_pkg::CH_W-1:0]      out_red,
  output logic [bblur_pkg::CH_W-1:0]      out_green,
  output logic [bblur_pkg::CH_W-1:0]      out_blue,
  output logic                            frame_last
);
  import bblur_pkg::*;

  bblur_cmd_t    cmd;
  bblur_status_t status;

  bblur_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bblur_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .cmd          (cmd),
    .status       (status),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .frame_last   (frame_last)
  );

  // A position that owes a result must be summed in the very next cycle.
  `BB_ASSERT_NEXT(a_emit_then_sum, cmd.step && status.emit, cmd.sum, "emitting step not summed")
  // The output register is only loaded when its previous result is gone or leaving.
  `BB_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_valid || !out_stall), "result overwritten")
  // A new result appears only through a load of the output register.
  `BB_ASSERT(a_valid_from_load, $rose(out_valid) |-> $past(cmd.load_out), "spurious out_valid")

endmodule

>>> bench/tb.sv
// Self-checking testbench for box_blur_3x3_edge_aware: predicts every blurred pixel and
// compares each output transfer with it. Depends on bblur_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
  import bblur_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1700;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_kind_t;

  typedef struct packed {
    pix_t color;
    logic frame_last;
  } blur_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 req_type;
  logic [CH_W-1:0]      in_red;
  logic [CH_W-1:0]      in_green;
  logic [CH_W-1:0]      in_blue;
  logic                 out_valid;
  logic                 out_stall;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic                 frame_last;

  box_blur_3x3_edge_aware dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .frame_last   (frame_last)
  );

  // Mirror of the block's frame state.
  int unsigned  pred_width;
  int unsigned  pred_height;
  int unsigned  pos_row;
  int unsigned  pos_col;
  pix_t         line_above [MAX_WIDTH];
  pix_t         line_mid   [MAX_WIDTH];
  pix_t         win_pix    [9];
  blur_result_t blurred_expected [$];

  int unsigned fails = 0;
  int unsigned effective_items = 0;
  int unsigned idle_count = 0;
  bit          no_idle = 1'b0;
  int          hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned maxv);
    int unsigned v;
    v = raw & 32'h7FF;
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void restart_frame();
    pos_row = 0;
    pos_col = 0;
    foreach (win_pix[i]) win_pix[i] = '0;
  endfunction

  function automatic void predictor_reset();
    pred_width  = WIDTH_RESET;
    pred_height = HEIGHT_RESET;
    foreach (line_above[i]) begin
      line_above[i] = '0;
      line_mid[i]   = '0;
    end
    restart_frame();
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    if (idx == REG_FRAME_WIDTH) begin
      pred_width = clamp_dim(value, MAX_WIDTH);
    end else begin
      pred_height = clamp_dim(value, MAX_HEIGHT);
    end
    restart_frame();
  endfunction

  function automatic pix_t window_mean(int col_lo, bit top_ok, bit bot_ok);
    int unsigned sr, sg, sb, n;
    int          row, col;
    pix_t        p, avg;
    sr = 0;
    sg = 0;
    sb = 0;
    n  = 0;
    for (row = 0; row < 3; row++) begin
      if ((row == 0 && !top_ok) || (row == 2 && !bot_ok)) continue;
      for (col = col_lo; col <= 2; col++) begin
        p = win_pix[row * 3 + col];
        sr += p.red;
        sg += p.green;
        sb += p.blue;
        n++;
      end
    end
    // Exact round half up of sum / n.
    avg.red   = CH_W'((2 * sr + n) / (2 * n));
    avg.green = CH_W'((2 * sg + n) / (2 * n));
    avg.blue  = CH_W'((2 * sb + n) / (2 * n));
    return avg;
  endfunction

  function automatic void shift_column(int unsigned c, pix_t pix);
    pix_t top, mid;
    int   row;
    top = line_above[c];
    mid = line_mid[c];
    line_above[c] = mid;
    line_mid[c]   = pix;
    for (row = 0; row < 3; row++) begin
      win_pix[row * 3]     = win_pix[row * 3 + 1];
      win_pix[row * 3 + 1] = win_pix[row * 3 + 2];
    end
    win_pix[2] = top;
    win_pix[5] = mid;
    win_pix[8] = pix;
  endfunction

  // One stream position, real or past the frame end.
  function automatic bit advance_position(pix_t pix, output blur_result_t res);
    int unsigned r, c;
    longint      k, total;
    bit          emit;
    r = pos_row;
    c = pos_col;
    k = longint'(r) * longint'(pred_width) + longint'(c) - longint'(pred_width) - 1;
    total = longint'(pred_width) * longint'(pred_height);
    emit = (k >= 0) && (k < total);
    res = '0;
    if (c == 0) begin
      // The centre is the last column of two rows back, still in window column 2.
      if (emit) res.color = window_mean((pred_width >= 2) ? 1 : 2, r >= 3, r <= pred_height);
      shift_column(c, pix);
    end else begin
      shift_column(c, pix);
      if (emit) res.color = window_mean((c >= 2) ? 0 : 1, r >= 2, r < pred_height);
    end
    pos_col = c + 1;
    if (pos_col >= pred_width) begin
      pos_col = 0;
      pos_row = r + 1;
    end
    if (emit) begin
      res.frame_last = (k == total - 1);
      if (res.frame_last) begin
        pos_row = 0;
        pos_col = 0;
      end
    end
    return emit;
  endfunction

  // Returns 0 when the block ignores the item.
  function automatic bit blur_predict(req_kind_t kind, pix_t pix);
    blur_result_t res;
    bit           got;
    if (pos_row < pred_height) begin
      if (kind == REQ_DRAIN) return 0;
      got = advance_position(pix, res);
    end else begin
      // Past the frame end every item drains; a position that yields nothing is skipped.
      got = advance_position('0, res);
      if (!got && pos_row >= pred_height) got = advance_position('0, res);
    end
    if (got) blurred_expected.push_back(res);
    return 1;
  endfunction

  function automatic pix_t random_pixel();
    return pix_t'($urandom);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  task automatic send_item(req_kind_t kind, pix_t pix);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    in_red   <= pix.red;
    in_green <= pix.green;
    in_blue  <= pix.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (blur_predict(kind, pix)) effective_items++;
  endtask

  // Wait out every expected result plus the work still in flight for items without one.
  task automatic go_idle();
    in_valid <= 1'b0;
    while (blurred_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= CFG_W'(value);
    @(posedge clk);
    apply_register(idx, value);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h);
    go_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic send_pixels(int unsigned count, bit noisy);
    for (int unsigned i = 0; i < count; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_item(REQ_DRAIN, random_pixel());
      send_item(REQ_PIXEL, random_pixel());
    end
  endtask

  // Pixels sent past the frame end act as drain steps too.
  task automatic drain_frame();
    while (pos_row >= pred_height) begin
      send_item(($urandom_range(0, 3) == 0) ? REQ_PIXEL : REQ_DRAIN, random_pixel());
    end
  endtask

  task automatic test_reset_size();
    // Default 640x480: only the first few results are reached before the next restart.
    send_pixels(644, 1'b0);
  endtask

  task automatic test_corner_cases();
    // Zero registers count as a 1x1 frame; its only result needs a skipped drain position.
    configure(0, 0);
    send_item(REQ_PIXEL, 24'hFF0080);
    send_item(REQ_DRAIN, 24'h000000);
    send_item(REQ_DRAIN, 24'h000000);
    send_item(REQ_PIXEL, 24'h00FF7F);
    send_item(REQ_PIXEL, 24'hFFFFFF);
    // 2x2 with a drain before the frame end, which the block ignores.
    configure(2, 2);
    send_item(REQ_PIXEL, 24'hFFFFFF);
    send_item(REQ_PIXEL, 24'h000000);
    send_item(REQ_DRAIN, 24'h123456);
    send_item(REQ_PIXEL, 24'h01FE00);
    send_item(REQ_PIXEL, 24'hFF00FF);
    drain_frame();
    configure(3, 1);
    send_item(REQ_PIXEL, 24'h000000);
    send_item(REQ_PIXEL, 24'hFFFFFF);
    send_item(REQ_PIXEL, 24'h010101);
    drain_frame();
  endtask

  task automatic test_max_width();
    // Values above the maximum saturate; the width shows up in the first results.
    configure(2047, 2047);
    send_pixels(1030, 1'b1);
  endtask

  task automatic test_max_height();
    configure(1, MAX_HEIGHT);
    send_pixels(pred_width * pred_height, 1'b0);
    drain_frame();
  endtask

  task automatic test_backpressure();
    configure(16, 6);
    hold_request = HOLD_CYCLES;
    send_pixels(pred_width * pred_height, 1'b0);
    drain_frame();
    // Back-to-back frame with no idling on either side.
    no_idle = 1'b1;
    send_pixels(pred_width * pred_height, 1'b0);
    drain_frame();
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned target, w, h, choice, n;
    target = effective_items + RANDOM_ITEMS;
    while (effective_items < target) begin
      choice = $urandom_range(0, 7);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 20);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      if (choice == 1) begin
        go_idle();
        write_reg(REG_FRAME_WIDTH, w);
      end else if (choice != 0) begin
        configure(w, h);
      end
      n = pred_width * pred_height;
      if ($urandom_range(0, 7) == 0) begin
        // Abandoned frame: a register write restarts it.
        send_pixels($urandom_range(0, n - 1), 1'b1);
        go_idle();
        write_reg(REG_FRAME_WIDTH, pred_width);
      end else begin
        send_pixels(n, 1'b1);
        drain_frame();
        if ($urandom_range(0, 5) == 0) send_item(REQ_DRAIN, random_pixel());
      end
    end
  endtask

  initial begin : receiver
    int n;
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    blur_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (blurred_expected.size() == 0) begin
        $error("unexpected result transfer: red %0d green %0d blue %0d frame_last %0d",
               out_red, out_green, out_blue, frame_last);
        fails++;
      end else begin
        want = blurred_expected.pop_front();
        check_field("out_red", want.color.red, out_red);
        check_field("out_green", want.color.green, out_green);
        check_field("out_blue", want.color.blue, out_blue);
        check_field("frame_last", want.frame_last, frame_last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    req_type     <= REQ_PIXEL;
    in_red       <= '0;
    in_green     <= '0;
    in_blue      <= '0;
    predictor_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_size();
    test_corner_cases();
    test_max_width();
    test_max_height();
    test_backpressure();
    test_random_frames();
    go_idle();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bblur_pkg.sv
hw/rtl/bblur_avg.sv
hw/rtl/bblur_dp.sv
hw/rtl/bblur_ctrl.sv
hw/rtl/box_blur_3x3_edge_aware.sv
bench/tb.sv
